// ===== hdl/ctl_pkg.sv =====
// ---------------------------------------------------------------------------
// ctl_pkg: shared constants and types of the curling tail length block
// Store sizes, counter widths, sequencer states and inter-module records.
// ---------------------------------------------------------------------------
`default_nettype none

package ctl_pkg;

	localparam int GEN_MAX  = 128;
	localparam int TAIL_MAX = 1024;
	localparam int DEPTH    = GEN_MAX + TAIL_MAX;
	localparam int AW       = $clog2(DEPTH);
	localparam int LW       = $clog2(DEPTH + 1);
	localparam int GW       = $clog2(GEN_MAX + 1);
	localparam int DW       = 16;
	localparam int CW       = 11;
	localparam int PW       = 2 * LW + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PER,
		S_WHILE,
		S_RD,
		S_CK,
		S_STEP,
		S_DONE
	} srch_state_t;

	typedef struct packed {
		logic          start;
		logic [LW-1:0] len;
		logic [LW-1:0] limit;
	} start_t;

	typedef struct packed {
		logic          done;
		logic          busy;
		logic [LW-1:0] tail;
		logic          trunc;
	} status_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] addr;
		logic [DW-1:0] data;
	} wr_t;

endpackage

`default_nettype wire

// ===== hdl/curling_tail_length.sv =====
// ---------------------------------------------------------------------------
// curling_tail_length: curling number tail builder
// Loads a generator, builds its curling tail and reports the tail length.
// ---------------------------------------------------------------------------
// Generator elements are taken one per cycle and written to a 1152-entry
// store; at most 128 are kept, later ones set the overflow flag. The request
// flagged last starts tail construction, during which no request is taken.
// Each tail step searches the curling number with a sequencer that compares
// one pair of store entries at a time through the store's two read ports;
// each compare passes through a read state and then a check state. The
// result is held in an output register; the next generator may load while
// it waits.
// ---------------------------------------------------------------------------
`default_nettype none

module curling_tail_length (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [ctl_pkg::CW-1:0]  cfg_wdata,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic signed [15:0]      value,
	input  wire logic                    last,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [ctl_pkg::CW-1:0]       tail_length,
	output logic                         truncated,
	output logic                         overflow
);

	logic [ctl_pkg::CW-1:0] tail_limit_q;
	logic [ctl_pkg::GW-1:0] gen_cnt_q;
	logic                   ovf_q;
	logic                   ovf_res_q;
	logic                   out_valid_q;
	logic [ctl_pkg::CW-1:0] tail_length_q;
	logic                   truncated_q;
	logic                   overflow_q;

	logic                   in_acc;
	logic                   gen_room;
	logic [ctl_pkg::GW-1:0] gen_next;
	logic                   done_ack;
	logic [ctl_pkg::LW-1:0] limit;
	ctl_pkg::start_t        start;
	ctl_pkg::status_t       status;
	ctl_pkg::wr_t           srch_wr;
	logic                   ram_we;
	logic [ctl_pkg::AW-1:0] ram_waddr;
	logic [ctl_pkg::DW-1:0] ram_wdata;
	logic [ctl_pkg::AW-1:0] raddr_a, raddr_b;
	logic [ctl_pkg::DW-1:0] rdata_a, rdata_b;

	assign in_stall = status.busy;
	assign in_acc   = in_valid && !status.busy;
	assign gen_room = (gen_cnt_q < ctl_pkg::GW'(ctl_pkg::GEN_MAX));
	assign gen_next = gen_room ? gen_cnt_q + ctl_pkg::GW'(1) : gen_cnt_q;
	assign done_ack = status.done && (!out_valid_q || !out_stall);

	// limit saturates at the tail capacity
	assign limit = (ctl_pkg::LW'(tail_limit_q) > ctl_pkg::LW'(ctl_pkg::TAIL_MAX))
		? ctl_pkg::LW'(ctl_pkg::TAIL_MAX) : ctl_pkg::LW'(tail_limit_q);

	assign start.start = in_acc && last;
	assign start.len   = ctl_pkg::LW'(gen_next);
	assign start.limit = limit;

	assign ram_we    = status.busy ? srch_wr.we : (in_acc && gen_room);
	assign ram_waddr = status.busy ? srch_wr.addr : ctl_pkg::AW'(gen_cnt_q);
	assign ram_wdata = status.busy ? srch_wr.data : value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_limit_q <= ctl_pkg::CW'(ctl_pkg::TAIL_MAX);
			gen_cnt_q    <= '0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				tail_limit_q <= cfg_wdata;
			end
			if (in_acc) begin
				if (last) begin
					gen_cnt_q <= '0;
					ovf_q     <= 1'b0;
				end else begin
					gen_cnt_q <= gen_next;
					ovf_q     <= ovf_q || !gen_room;
				end
			end
			if (done_ack) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start.start) begin
			ovf_res_q <= ovf_q || !gen_room;
		end
		if (done_ack) begin
			tail_length_q <= ctl_pkg::CW'(status.tail);
			truncated_q   <= status.trunc;
			overflow_q    <= ovf_res_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign tail_length = tail_length_q;
	assign truncated   = truncated_q;
	assign overflow    = overflow_q;

	ctl_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.done_ack (done_ack),
		.status   (status),
		.wr       (srch_wr),
		.raddr_a  (raddr_a),
		.raddr_b  (raddr_b),
		.rdata_a  (rdata_a),
		.rdata_b  (rdata_b)
	);

	ctl_ram #(
		.WIDTH (ctl_pkg::DW),
		.DEPTH (ctl_pkg::DEPTH)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

endmodule

`default_nettype wire

// ===== hdl/ctl_ram.sv =====
// ---------------------------------------------------------------------------
// ctl_ram: generic synchronous RAM
// One write port, two read ports, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module ctl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1152
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

// ===== hdl/ctl_search.sv =====
// ---------------------------------------------------------------------------
// ctl_search: curling number sequencer
// Walks the store and appends curling numbers until limit, full store or one.
// ---------------------------------------------------------------------------
`default_nettype none

module ctl_search (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ctl_pkg::start_t        start,
	input  wire logic                   done_ack,
	output ctl_pkg::status_t            status,
	output ctl_pkg::wr_t                wr,
	output logic [ctl_pkg::AW-1:0]      raddr_a,
	output logic [ctl_pkg::AW-1:0]      raddr_b,
	input  wire logic [ctl_pkg::DW-1:0] rdata_a,
	input  wire logic [ctl_pkg::DW-1:0] rdata_b
);

	ctl_pkg::srch_state_t state_q, state_d;

	logic [ctl_pkg::LW-1:0] len_q, len_d;
	logic [ctl_pkg::LW-1:0] curl_q, curl_d;
	logic [ctl_pkg::LW-1:0] per_q, per_d;
	logic [ctl_pkg::LW-1:0] lstart_q, lstart_d;
	logic [ctl_pkg::LW-1:0] prev_q, prev_d;
	logic [ctl_pkg::LW-1:0] reps_q, reps_d;
	logic [ctl_pkg::LW-1:0] idx_q, idx_d;
	logic [ctl_pkg::LW-1:0] tail_q, tail_d;
	logic [ctl_pkg::LW-1:0] limit_q, limit_d;
	logic                   trunc_q, trunc_d;
	logic [ctl_pkg::PW-1:0] span;
	logic [ctl_pkg::LW-1:0] addr_a, addr_b;

	// per <= len/(curl+1) checked as per*(curl+1) <= len
	assign span   = ctl_pkg::PW'(per_q) * (ctl_pkg::PW'(curl_q) + ctl_pkg::PW'(1));
	assign addr_a = lstart_q + idx_q;
	assign addr_b = prev_q + idx_q;
	assign raddr_a = addr_a[ctl_pkg::AW-1:0];
	assign raddr_b = addr_b[ctl_pkg::AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		len_q    <= len_d;
		curl_q   <= curl_d;
		per_q    <= per_d;
		lstart_q <= lstart_d;
		prev_q   <= prev_d;
		reps_q   <= reps_d;
		idx_q    <= idx_d;
		tail_q   <= tail_d;
		limit_q  <= limit_d;
		trunc_q  <= trunc_d;
	end

	always_comb begin
		state_d  = state_q;
		len_d    = len_q;
		curl_d   = curl_q;
		per_d    = per_q;
		lstart_d = lstart_q;
		prev_d   = prev_q;
		reps_d   = reps_q;
		idx_d    = idx_q;
		tail_d   = tail_q;
		limit_d  = limit_q;
		trunc_d  = trunc_q;
		wr.we    = 1'b0;
		wr.addr  = len_q[ctl_pkg::AW-1:0];
		wr.data  = ctl_pkg::DW'(curl_q);
		unique case (state_q)
			ctl_pkg::S_IDLE: begin
				if (start.start) begin
					len_d   = start.len;
					limit_d = start.limit;
					curl_d  = ctl_pkg::LW'(1);
					per_d   = ctl_pkg::LW'(1);
					tail_d  = '0;
					trunc_d = 1'b0;
					state_d = ctl_pkg::S_PER;
				end
			end
			ctl_pkg::S_PER: begin
				if (span > ctl_pkg::PW'(len_q)) begin
					state_d = ctl_pkg::S_STEP;
				end else begin
					lstart_d = len_q - per_q;
					prev_d   = len_q - per_q;
					reps_d   = ctl_pkg::LW'(2);
					state_d  = ctl_pkg::S_WHILE;
				end
			end
			ctl_pkg::S_WHILE: begin
				if (prev_q >= per_q) begin
					prev_d  = prev_q - per_q;
					idx_d   = '0;
					state_d = ctl_pkg::S_RD;
				end else begin
					per_d   = per_q + ctl_pkg::LW'(1);
					state_d = ctl_pkg::S_PER;
				end
			end
			ctl_pkg::S_RD: begin
				state_d = ctl_pkg::S_CK;
			end
			ctl_pkg::S_CK: begin
				priority if (rdata_a != rdata_b) begin
					per_d   = per_q + ctl_pkg::LW'(1);
					state_d = ctl_pkg::S_PER;
				end else if (idx_q == per_q - ctl_pkg::LW'(1)) begin
					if (curl_q < reps_q) begin
						curl_d = reps_q;
					end
					reps_d  = reps_q + ctl_pkg::LW'(1);
					state_d = ctl_pkg::S_WHILE;
				end else begin
					idx_d   = idx_q + ctl_pkg::LW'(1);
					state_d = ctl_pkg::S_RD;
				end
			end
			ctl_pkg::S_STEP: begin
				priority if (curl_q == ctl_pkg::LW'(1)) begin
					state_d = ctl_pkg::S_DONE;
				end else if (tail_q >= limit_q || len_q >= ctl_pkg::LW'(ctl_pkg::DEPTH)) begin
					trunc_d = 1'b1;
					state_d = ctl_pkg::S_DONE;
				end else begin
					wr.we   = 1'b1;
					len_d   = len_q + ctl_pkg::LW'(1);
					tail_d  = tail_q + ctl_pkg::LW'(1);
					curl_d  = ctl_pkg::LW'(1);
					per_d   = ctl_pkg::LW'(1);
					state_d = ctl_pkg::S_PER;
				end
			end
			ctl_pkg::S_DONE: begin
				if (done_ack) begin
					state_d = ctl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ctl_pkg::S_IDLE;
			end
		endcase
	end

	assign status.done  = (state_q == ctl_pkg::S_DONE);
	assign status.busy  = (state_q != ctl_pkg::S_IDLE);
	assign status.tail  = tail_q;
	assign status.trunc = trunc_q;

endmodule

`default_nettype wire
